[rtl/assert_macros.svh]
// Assertion macros used by the grid visibility RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication within the same cycle.
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check an implication in the following cycle.
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GRC_ASSERT_NOW(lbl, ante, cons, msg)
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/grc_pkg.sv]
// Package for the grid visibility block: constants, codes, FSM type, sine table.
// No dependencies.
package grc_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_RANGE  = 31;
	localparam int ANGLE_STEPS    = 360;

	localparam int CRD_W = 10; // signed tile coordinate on a ray
	localparam int RNG_W = 7;  // sight radius
	localparam int MAG_W = 8;  // endpoint offset magnitude
	localparam int REM_W = 9;  // stepping remainder

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_VIEW  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_RD,
		ST_RD_DATA,
		ST_GCLR,
		ST_RAY,
		ST_RAY_INIT,
		ST_STEP,
		ST_CHECK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic        neg;
		logic [16:0] mag;
	} trig_t;

	// round(65536*sin(k degrees)), k = 0..90
	function automatic logic [16:0] sin_tbl(input logic [6:0] k);
		logic [16:0] v;
		case (k)
			7'd0: v = 17'd0;      7'd1: v = 17'd1144;   7'd2: v = 17'd2287;
			7'd3: v = 17'd3430;   7'd4: v = 17'd4572;   7'd5: v = 17'd5712;
			7'd6: v = 17'd6850;   7'd7: v = 17'd7987;   7'd8: v = 17'd9121;
			7'd9: v = 17'd10252;  7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
			7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
			7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
			7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
			7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
			7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
			7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
			7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
			7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
			7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
			7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
			7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
			7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
			7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
			7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
			7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
			7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
			7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
			7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
			7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
			7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
			7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
			7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
			7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
			7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
			7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
			7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

	// Sine of a whole-degree angle 0..359 as sign and Q1.16 magnitude
	function automatic trig_t sin_deg(input logic [8:0] a);
		trig_t       t;
		logic [8:0]  r;
		logic        odd;
		if (a < 9'd90) begin
			r = a; odd = 1'b0; t.neg = 1'b0;
		end else if (a < 9'd180) begin
			r = a - 9'd90; odd = 1'b1; t.neg = 1'b0;
		end else if (a < 9'd270) begin
			r = a - 9'd180; odd = 1'b0; t.neg = 1'b1;
		end else begin
			r = a - 9'd270; odd = 1'b1; t.neg = 1'b1;
		end
		t.mag = odd ? sin_tbl(7'(9'd90 - r)) : sin_tbl(r[6:0]);
		return t;
	endfunction

endpackage

[rtl/grid_ray_cast_visibility_top.sv]
// Top level of the grid visibility block: tile stores, ray stepper, APB registers.
// Depends on grc_pkg and assert_macros.svh.
//
// Keeps wall, seen and glare bits for a MAX_WIDTH x MAX_HEIGHT grid in two
// single-port-write memories (wall+seen, glare), each with a registered
// read. Every request gives exactly one result transfer; only a read returns
// non-zero bits. After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// entries zeroes both memories; in_ready stays low until it ends, while
// register writes are taken as ever. A write request steps through accept,
// read, write back and result, and a read through accept, read, capture and
// result. A view request first sweeps the glare memory, then walks 360 rays:
// for each ray it scales the endpoint and sets up the stepper, then steps
// along the ray, reading each in-map tile and then writing it back, and
// passing off-map tiles without a memory access. The memory read latency
// and the read-then-write of each visited tile set the step rate. Stepping
// uses running quotient/remainder pairs, so no divider is needed. The next
// request is taken as soon as the result sits in the output register, even
// if it has not yet been transferred.
module grid_ray_cast_visibility_top
	import grc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RANGE  = DEF_MAX_RANGE
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [5:0]  pos_x,
	input  logic [5:0]  pos_y,
	input  logic        is_wall,
	input  logic [4:0]  view_range,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tile_wall,
	output logic        tile_seen,
	output logic        tile_glare
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// registers
	logic [6:0] map_w_q, map_h_q;
	logic [8:0] eff_w, eff_h;

	// FSM and request context
	state_t          state_q, state_d;
	logic [1:0]      req_q;
	logic            wall_q;
	logic [5:0]      vx_q, vy_q;
	logic [RNG_W-1:0] range_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   clr_q;

	// ray stepper
	logic [8:0]       ang_q;
	logic [MAG_W-1:0] dxm_q, dym_q, n_q, j_q, qx_q, qy_q;
	logic             dxn_q, dyn_q;
	logic [REM_W-1:0] rx_q, ry_q;
	logic [AW-1:0]    step_addr_q;

	// result holding
	logic res_wall_q, res_seen_q, res_glare_q;
	logic out_valid_q, out_wall_q, out_seen_q, out_glare_q;

	// memories
	logic [1:0] ws_mem [DEPTH];
	logic       g_mem  [DEPTH];
	logic [1:0] ws_rd_q;
	logic       g_rd_q;
	logic       ws_we, g_we, rd_en;
	logic [AW-1:0] ws_wa, g_wa, rd_addr;
	logic [1:0] ws_wd;
	logic       g_wd;

	function automatic logic [AW-1:0] addr_of(input logic [8:0] ty, input logic [8:0] tx);
		logic [16:0] full;
		full = 17'(ty) * 17'(MAX_WIDTH) + 17'(tx);
		return full[AW-1:0];
	endfunction

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign prdata = 32'((paddr[2] == CFG_HEIGHT) ? map_h_q : map_w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= 7'd64;
			map_h_q <= 7'd64;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == CFG_HEIGHT) map_h_q <= pwdata[6:0];
			else                        map_w_q <= pwdata[6:0];
		end
	end

	// clamp the map to the store
	assign eff_w = (9'(map_w_q) < 9'(MAX_WIDTH))  ? 9'(map_w_q) : 9'(MAX_WIDTH);
	assign eff_h = (9'(map_h_q) < 9'(MAX_HEIGHT)) ? 9'(map_h_q) : 9'(MAX_HEIGHT);

	// ---------------- request decode at transfer ----------------
	logic in_xfer, acc_inside;
	logic [RNG_W-1:0] range_sat;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign acc_inside = (9'(pos_x) < eff_w) && (9'(pos_y) < eff_h);
	assign range_sat  = (RNG_W'(view_range) > RNG_W'(MAX_RANGE)) ? RNG_W'(MAX_RANGE)
		: RNG_W'(view_range);

	// ---------------- endpoint scaling ----------------
	trig_t       sn, cs;
	logic [9:0]  cos_ang10;
	logic [23:0] px_prod, py_prod;
	logic [23:0] px_rnd, py_rnd;
	assign cos_ang10 = 10'(ang_q) + 10'd90;
	assign sn = sin_deg(ang_q);
	assign cs = sin_deg((cos_ang10 >= 10'(ANGLE_STEPS)) ? 9'(cos_ang10 - 10'(ANGLE_STEPS))
		: cos_ang10[8:0]);
	assign px_prod = 24'(cs.mag) * 24'(range_q);
	assign py_prod = 24'(sn.mag) * 24'(range_q);
	assign px_rnd  = px_prod + 24'd32768;
	assign py_rnd  = py_prod + 24'd65536;

	// ---------------- current tile on the ray ----------------
	logic signed [CRD_W-1:0] tx, ty;
	logic step_inside, at_viewer, last_step, last_ray;
	assign tx = CRD_W'(vx_q) + (dxn_q ? -CRD_W'(qx_q) : CRD_W'(qx_q));
	assign ty = CRD_W'(vy_q) + (dyn_q ? -CRD_W'(qy_q) : CRD_W'(qy_q));
	assign step_inside = !tx[CRD_W-1] && !ty[CRD_W-1]
		&& (tx[8:0] < eff_w) && (ty[8:0] < eff_h);
	assign at_viewer = (qx_q == '0) && (qy_q == '0);
	assign last_step = (j_q == n_q);
	assign last_ray  = (ang_q == 9'(ANGLE_STEPS - 1));

	// next quotient/remainder: the rounded fraction grows by at most one a step
	logic [REM_W:0]   rx_sum, ry_sum, two_n;
	logic [REM_W-1:0] rx_nxt, ry_nxt;
	logic             qx_inc, qy_inc;
	assign two_n  = (REM_W+1)'({n_q, 1'b0});
	assign rx_sum = (REM_W+1)'(rx_q) + (REM_W+1)'({dxm_q, 1'b0});
	assign ry_sum = (REM_W+1)'(ry_q) + (REM_W+1)'({dym_q, 1'b0});
	assign qx_inc = (rx_sum >= two_n);
	assign qy_inc = (ry_sum >= two_n);
	assign rx_nxt = REM_W'(qx_inc ? rx_sum - two_n : rx_sum);
	assign ry_nxt = REM_W'(qy_inc ? ry_sum - two_n : ry_sum);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// ---------------- next state and memory control ----------------
	always_comb begin
		state_d = state_q;
		ws_we = 1'b0; ws_wa = addr_q; ws_wd = 2'b00;
		g_we  = 1'b0; g_wa  = addr_q; g_wd  = 1'b0;
		rd_en = 1'b0; rd_addr = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ws_we = 1'b1; ws_wa = clr_q;
				g_we  = 1'b1; g_wa  = clr_q;
				if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_xfer) begin
					case (req_type)
						REQ_WRITE: state_d = acc_inside ? ST_WR_RD : ST_RESP;
						REQ_VIEW:  state_d = ST_GCLR;
						REQ_READ:  state_d = acc_inside ? ST_RD : ST_RESP;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_WR_RD: begin
				rd_en = 1'b1;
				state_d = ST_WR_WB;
			end
			ST_WR_WB: begin
				ws_we = 1'b1;
				ws_wd = {wall_q, ws_rd_q[0]};
				state_d = ST_RESP;
			end
			ST_RD: begin
				rd_en = 1'b1;
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: state_d = ST_RESP;
			ST_GCLR: begin
				g_we = 1'b1; g_wa = clr_q;
				if (clr_q == AW'(DEPTH - 1)) state_d = ST_RAY;
			end
			ST_RAY:      state_d = ST_RAY_INIT;
			ST_RAY_INIT: state_d = ST_STEP;
			ST_STEP: begin
				if (step_inside) begin
					rd_en = 1'b1;
					rd_addr = addr_of(ty[8:0], tx[8:0]);
					state_d = ST_CHECK;
				end else if (last_step) begin
					state_d = last_ray ? ST_RESP : ST_RAY;
				end
			end
			ST_CHECK: begin
				ws_wa = step_addr_q;
				g_wa  = step_addr_q;
				if (ws_rd_q[1]) begin
					// wall: mark seen, end the ray
					ws_we = 1'b1; ws_wd = 2'b11;
					state_d = last_ray ? ST_RESP : ST_RAY;
				end else begin
					if (!at_viewer) begin
						ws_we = 1'b1; ws_wd = 2'b01;
						g_we  = 1'b1; g_wd  = 1'b1;
					end
					if (last_step) state_d = last_ray ? ST_RESP : ST_RAY;
					else           state_d = ST_STEP;
				end
			end
			ST_RESP: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (ws_we) ws_mem[ws_wa] <= ws_wd;
		if (rd_en) ws_rd_q <= ws_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (g_we) g_mem[g_wa] <= g_wd;
		if (rd_en) g_rd_q <= g_mem[rd_addr];
	end

	// ---------------- sweep counter ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR || state_q == ST_GCLR) begin
			clr_q <= (clr_q == AW'(DEPTH - 1)) ? '0 : clr_q + 1'b1;
		end
	end

	// ---------------- request context and stepper ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					req_q   <= req_type;
					wall_q  <= is_wall;
					vx_q    <= pos_x;
					vy_q    <= pos_y;
					range_q <= range_sat;
					addr_q  <= addr_of(9'(pos_y), 9'(pos_x));
					ang_q   <= '0;
					res_wall_q  <= 1'b0;
					res_seen_q  <= 1'b0;
					res_glare_q <= 1'b0;
				end
			end
			ST_RD_DATA: begin
				res_wall_q  <= ws_rd_q[1];
				res_seen_q  <= ws_rd_q[0];
				res_glare_q <= g_rd_q;
			end
			ST_RAY: begin
				dxm_q <= px_rnd[23:16];
				dym_q <= MAG_W'(py_rnd[23:17]);
				dxn_q <= cs.neg;
				dyn_q <= sn.neg;
			end
			ST_RAY_INIT: begin
				n_q  <= (dxm_q > dym_q) ? dxm_q : dym_q;
				rx_q <= REM_W'((dxm_q > dym_q) ? dxm_q : dym_q);
				ry_q <= REM_W'((dxm_q > dym_q) ? dxm_q : dym_q);
				j_q  <= '0;
				qx_q <= '0;
				qy_q <= '0;
			end
			ST_STEP: begin
				step_addr_q <= addr_of(ty[8:0], tx[8:0]);
				if (!step_inside) begin
					if (last_step) begin
						ang_q <= ang_q + 1'b1;
					end else begin
						j_q  <= j_q + 1'b1;
						rx_q <= rx_nxt; qx_q <= qx_q + MAG_W'(qx_inc);
						ry_q <= ry_nxt; qy_q <= qy_q + MAG_W'(qy_inc);
					end
				end
			end
			ST_CHECK: begin
				if (ws_rd_q[1] || last_step) begin
					ang_q <= ang_q + 1'b1;
				end else begin
					j_q  <= j_q + 1'b1;
					rx_q <= rx_nxt; qx_q <= qx_q + MAG_W'(qx_inc);
					ry_q <= ry_nxt; qy_q <= qy_q + MAG_W'(qy_inc);
				end
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			// only a read carries tile bits
			out_wall_q  <= (req_q == REQ_READ) && res_wall_q;
			out_seen_q  <= (req_q == REQ_READ) && res_seen_q;
			out_glare_q <= (req_q == REQ_READ) && res_glare_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign tile_wall  = out_wall_q;
	assign tile_seen  = out_seen_q;
	assign tile_glare = out_glare_q;

	// ---------------- assertions ----------------
`include "assert_macros.svh"
	`GRC_ASSERT_NOW(a_idle_no_write, state_q == ST_IDLE, !ws_we && !g_we, "write while idle")
	`GRC_ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state_q != ST_IDLE, "request not started")
	`GRC_ASSERT_NOW(a_step_in_ray, state_q == ST_STEP, j_q <= n_q, "step past ray end")
	`GRC_ASSERT_NOW(a_rem_bound, state_q == ST_STEP, (n_q == '0) || (rx_q < two_n), "remainder")

endmodule

[dv/grid_ray_cast_visibility_top_tb.sv]
// Self-checking testbench for grid_ray_cast_visibility_top: tile writes, reads and
// ray-cast views checked against an in-bench visibility predictor.
// Depends on grc_pkg and the RTL of the block; reads no files.
module grid_ray_cast_visibility_top_tb
	import grc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_SPARE = 2'd3;   // undefined request code
	localparam int         GRID_COLS = 64;
	localparam int         GRID_ROWS = 64;
	localparam int         RANGE_CAP = 31;
	localparam int         RAY_COUNT = 360;
	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	// Q1.16 sine for whole degrees 0..90
	localparam int SINE_Q16 [91] = '{
		0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
		11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
		22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
		32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
		42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
		50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
		56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
		61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
		64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
		65536
	};

	typedef struct packed {
		logic wall;
		logic seen;
		logic glare;
	} tile_bits_t;

	// Scoreboard: mirrors the tile stores and keeps the tile bits still owed.
	class tile_scoreboard;
		bit          wall_map  [GRID_COLS*GRID_ROWS];
		bit          seen_map  [GRID_COLS*GRID_ROWS];
		bit          glare_map [GRID_COLS*GRID_ROWS];
		int          cols = 64;
		int          rows = 64;
		tile_bits_t  owed [$];
		int          errors = 0;

		function int used_cols();
			return (cols < GRID_COLS) ? cols : GRID_COLS;
		endfunction

		function int used_rows();
			return (rows < GRID_ROWS) ? rows : GRID_ROWS;
		endfunction

		function int sine_deg(int a);
			int q, r, v;
			a = a % 360;
			q = a / 90;
			r = a % 90;
			v = (q % 2 == 1) ? SINE_Q16[90-r] : SINE_Q16[r];
			return (q >= 2) ? -v : v;
		endfunction

		// round(s*mul / 2^sh), half away from zero
		function int scale_half_away(int s, int mul, int sh);
			int m, r;
			m = ((s < 0) ? -s : s) * mul;
			r = (m + (1 << (sh - 1))) >>> sh;
			return (s < 0) ? -r : r;
		endfunction

		// round(j*d/n), half away from zero
		function int step_offset(int d, int j, int n);
			int m, r;
			m = ((d < 0) ? -d : d) * j;
			r = (2*m + n) / (2*n);
			return (d < 0) ? -r : r;
		endfunction

		function void cast_rays(int vx, int vy, int radius);
			int w, h, dx, dy, ax, ay, n, tx, ty, idx;
			w = used_cols();
			h = used_rows();
			foreach (glare_map[k]) glare_map[k] = 0;
			for (int i = 0; i < RAY_COUNT; i++) begin
				dx = scale_half_away(sine_deg(i + 90), radius, 16);
				dy = scale_half_away(sine_deg(i), radius, 17);
				ax = (dx < 0) ? -dx : dx;
				ay = (dy < 0) ? -dy : dy;
				n = (ax > ay) ? ax : ay;
				for (int j = 0; j <= n; j++) begin
					tx = vx;
					ty = vy;
					if (n != 0) begin
						tx += step_offset(dx, j, n);
						ty += step_offset(dy, j, n);
					end
					if (tx < 0 || tx >= w || ty < 0 || ty >= h) continue;
					idx = ty*GRID_COLS + tx;
					if (wall_map[idx]) begin
						seen_map[idx] = 1;
						break;
					end
					if (tx == vx && ty == vy) continue;
					glare_map[idx] = 1;
					seen_map[idx]  = 1;
				end
			end
		endfunction

		function void note_request(logic [1:0] kind, logic [5:0] x, logic [5:0] y,
				logic wall, logic [4:0] radius);
			tile_bits_t exp_bits;
			bit on_map;
			int idx;
			exp_bits = '0;
			on_map = (int'(x) < used_cols()) && (int'(y) < used_rows());
			idx = int'(y)*GRID_COLS + int'(x);
			case (kind)
				REQ_WRITE: if (on_map) wall_map[idx] = wall;
				REQ_VIEW: cast_rays(int'(x), int'(y),
					(int'(radius) > RANGE_CAP) ? RANGE_CAP : int'(radius));
				REQ_READ: if (on_map) begin
					exp_bits.wall  = wall_map[idx];
					exp_bits.seen  = seen_map[idx];
					exp_bits.glare = glare_map[idx];
				end
				default: ;
			endcase
			owed.push_back(exp_bits);
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(logic w, logic s, logic g);
			tile_bits_t want;
			if (owed.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
				return;
			end
			want = owed.pop_front();
			if (w !== want.wall)  report_mismatch("tile_wall", w, want.wall);
			if (s !== want.seen)  report_mismatch("tile_seen", s, want.seen);
			if (g !== want.glare) report_mismatch("tile_glare", g, want.glare);
		endtask

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic [5:0]  pos_x = '0, pos_y = '0;
	logic        is_wall = 1'b0;
	logic [4:0]  view_range = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        tile_wall, tile_seen, tile_glare;

	tile_scoreboard sb = new();
	int burst_left = 0;
	int stall_left = 0;
	int calm_left  = 0;

	grid_ray_cast_visibility_top u_top (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready, .req_type, .pos_x, .pos_y, .is_wall, .view_range,
		.out_valid, .out_ready, .tile_wall, .tile_seen, .tile_glare
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: calm stretches with no stall, long stalls, and coin-flip cycles
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (calm_left > 0) begin
			calm_left--;
			out_ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					calm_left = $urandom_range(10, 80);
					out_ready <= 1'b1;
				end
				1: begin
					stall_left = $urandom_range(1, 20);
					out_ready <= 1'b0;
				end
				default: out_ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// Check every result transfer against the oldest owed tile bits
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(tile_wall, tile_seen, tile_glare);
	end

	// Register write: setup cycle, then access cycle; pready is tied high
	task apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_WIDTH) sb.cols = data[6:0];
		else sb.rows = data[6:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Present one request, in bursts with random gaps, and hold it until transfer
	task send_request(logic [1:0] kind, logic [5:0] x, logic [5:0] y, logic wall,
			logic [4:0] radius);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		req_type   <= kind;
		pos_x      <= x;
		pos_y      <= y;
		is_wall    <= wall;
		view_range <= radius;
		do @(posedge clk); while (!in_ready);
		sb.note_request(kind, x, y, wall, radius);
		burst_left--;
	endtask

	// Drop valid and hold off until every owed result has come back
	task drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function logic [5:0] near(int c, int spread);
		int v;
		v = c + $urandom_range(0, 2*spread) - spread;
		if (v < 0) v = 0;
		if (v > 63) v = 63;
		return v[5:0];
	endfunction

	// Scene: walls near a viewer, one view, then reads around the viewer
	task run_scene(output int issued);
		int vx, vy, radius, nwalls, nreads, w, h;
		w = sb.used_cols();
		h = sb.used_rows();
		issued = 0;
		if ($urandom_range(0, 4) != 0 && w > 0 && h > 0) begin
			vx = $urandom_range(0, w - 1);
			vy = $urandom_range(0, h - 1);
		end else begin
			vx = $urandom_range(0, 63);
			vy = $urandom_range(0, 63);
		end
		case ($urandom_range(0, 9))
			0:       radius = $urandom_range(16, 31);
			1, 2:    radius = $urandom_range(7, 15);
			default: radius = $urandom_range(0, 6);
		endcase
		nwalls = $urandom_range(0, 6);
		for (int k = 0; k < nwalls; k++) begin
			send_request(REQ_WRITE, near(vx, 4), near(vy, 4), $urandom_range(0, 4) != 0, '0);
			issued++;
		end
		send_request(REQ_VIEW, vx[5:0], vy[5:0], 1'b0, radius[4:0]);
		issued++;
		nreads = $urandom_range(3, 8);
		for (int k = 0; k < nreads; k++) begin
			send_request(REQ_READ, near(vx, radius + 1), near(vy, radius / 2 + 1), 1'b0, '0);
			issued++;
		end
	endtask

	// Noise: any field pattern, request codes kept mostly cheap
	task send_noise();
		logic [1:0] kind;
		kind = 2'($urandom_range(0, 3));
		if (kind == REQ_VIEW && $urandom_range(0, 2) != 0) kind = REQ_READ;
		send_request(kind, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
	endtask

	int phase_cols [6] = '{64, 0, 1, 127, 20, 64};
	int phase_rows [6] = '{64, 5, 1, 127, 37, 64};

	initial begin
		int sent, got;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the default grid
		send_request(REQ_WRITE, 6'd63, 6'd63, 1'b1, '0);
		send_request(REQ_READ,  6'd63, 6'd63, 1'b0, '0);
		send_request(REQ_READ,  6'd0,  6'd0,  1'b0, '0);
		// viewer standing on a wall
		send_request(REQ_WRITE, 6'd5, 6'd5, 1'b1, '0);
		send_request(REQ_VIEW,  6'd5, 6'd5, 1'b0, 5'd3);
		send_request(REQ_READ,  6'd5, 6'd5, 1'b0, '0);
		send_request(REQ_READ,  6'd6, 6'd5, 1'b0, '0);
		send_request(REQ_WRITE, 6'd5, 6'd5, 1'b0, '0);
		// wall ending a ray, widest radius from the corner
		send_request(REQ_WRITE, 6'd3, 6'd0, 1'b1, '0);
		send_request(REQ_VIEW,  6'd0, 6'd0, 1'b0, 5'd31);
		send_request(REQ_READ,  6'd3, 6'd0, 1'b0, '0);
		send_request(REQ_READ,  6'd5, 6'd0, 1'b0, '0);
		send_request(REQ_READ,  6'd0, 6'd15, 1'b0, '0);
		send_request(REQ_READ,  6'd1, 6'd1, 1'b0, '0);
		// zero radius: only the viewer tile, which is never lit
		send_request(REQ_VIEW,  6'd40, 6'd40, 1'b0, 5'd0);
		send_request(REQ_READ,  6'd40, 6'd40, 1'b0, '0);
		send_request(REQ_READ,  6'd1, 6'd1, 1'b0, '0);
		send_request(REQ_SPARE, 6'd63, 6'd63, 1'b1, 5'd31);
		send_request(REQ_READ,  6'd63, 6'd0, 1'b0, '0);

		for (int p = 0; p < 6; p++) begin
			drain_results();
			apb_write(ADDR_WIDTH, phase_cols[p]);
			apb_write(ADDR_HEIGHT, phase_rows[p]);
			sent = 0;
			while (sent < 16) begin
				if ($urandom_range(0, 4) != 0) begin
					run_scene(got);
					sent += got;
				end else begin
					send_noise();
					sent++;
				end
				// Hold off once mid-phase until the block has caught up
				if (p == 2 && sent > 10 && sent < 14) begin
					drain_results();
					sent = 14;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("grid_ray_cast_visibility_top_tb: PASS");
		end else begin
			$display("grid_ray_cast_visibility_top_tb: FAIL");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest legal run
	initial begin
		#60ms;
		$display("grid_ray_cast_visibility_top_tb: FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/grc_pkg.sv
rtl/grid_ray_cast_visibility_top.sv
dv/grid_ray_cast_visibility_top_tb.sv
